### design/aabcd_pkg.sv
package aabcd_pkg;

  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_OR   = 3'd1;
  localparam logic [2:0] CMD_AND  = 3'd2;
  localparam logic [2:0] CMD_XOR  = 3'd3;
  localparam logic [2:0] CMD_ADD  = 3'd4;

  localparam logic [4:0] DEC_DIGIT_MAX = 5'd9;
  localparam logic [5:0] DEC_ADJUST    = 6'd6;
  localparam int unsigned DIGITS       = 4;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] operand;
    logic        narrow_mode;
    logic        decimal_mode;
    logic        carry_in;
    logic        overflow_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] accumulator_out;
    logic        negative;
    logic        zero;
    logic        overflow_out;
    logic        carry_out;
  } out_item_t;

endpackage

### design/aabcd_in_stage.sv
module aabcd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aabcd_pkg::in_item_t in_data,
  input  logic                advance,
  output logic                s1_valid,
  output aabcd_pkg::in_item_t s1_item
);

  logic                s1_valid_r;
  aabcd_pkg::in_item_t s1_item_r;
  logic                load;

  // hold while the stored item cannot move on to the result register
  assign in_stall = s1_valid_r && !advance;
  assign load     = in_valid && !in_stall;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_data;
    end
  end

endmodule

### design/aabcd_alu.sv
module aabcd_alu (
  input  logic [15:0]          acc,
  input  aabcd_pkg::in_item_t  item,
  output logic [15:0]          acc_nxt,
  output aabcd_pkg::out_item_t res
);

  logic [15:0] a;
  logic [15:0] b;
  logic [15:0] r;
  logic        cout;
  logic        vout;
  logic [16:0] bin16;
  logic [8:0]  bin8;
  logic [15:0] dec_sum;
  logic [4:0]  dcarry;
  logic [1:0]  dv;

  assign a = item.narrow_mode ? {8'h00, acc[7:0]} : acc;
  assign b = item.narrow_mode ? {8'h00, item.operand[7:0]} : item.operand;

  assign bin16 = {1'b0, a} + {1'b0, b} + {16'h0000, item.carry_in};
  assign bin8  = {1'b0, a[7:0]} + {1'b0, b[7:0]} + {8'h00, item.carry_in};

  // digit-wise decimal add; overflow taken from the top digit before adjust
  always_comb begin
    logic [4:0] d;
    logic [5:0] da;
    dcarry[0] = item.carry_in;
    dv        = 2'b00;
    dec_sum   = 16'h0000;
    for (int i = 0; i < aabcd_pkg::DIGITS; i++) begin
      d  = {1'b0, a[4*i +: 4]} + {1'b0, b[4*i +: 4]} + {4'h0, dcarry[i]};
      if (i == 1) begin
        dv[0] = ~(a[4*i+3] ^ b[4*i+3]) & (a[4*i+3] ^ d[3]);
      end
      if (i == 3) begin
        dv[1] = ~(a[4*i+3] ^ b[4*i+3]) & (a[4*i+3] ^ d[3]);
      end
      da = (d > aabcd_pkg::DEC_DIGIT_MAX) ? ({1'b0, d} + aabcd_pkg::DEC_ADJUST) : {1'b0, d};
      dcarry[i+1]       = (da > 6'd15);
      dec_sum[4*i +: 4] = da[3:0];
    end
  end

  always_comb begin
    r    = a;
    cout = item.carry_in;
    vout = item.overflow_in;
    unique case (item.command)
      aabcd_pkg::CMD_LOAD: r = b;
      aabcd_pkg::CMD_OR:   r = a | b;
      aabcd_pkg::CMD_AND:  r = a & b;
      aabcd_pkg::CMD_XOR:  r = a ^ b;
      aabcd_pkg::CMD_ADD: begin
        priority if (item.decimal_mode && item.narrow_mode) begin
          r    = {8'h00, dec_sum[7:0]};
          cout = dcarry[2];
          vout = dv[0];
        end else if (item.decimal_mode) begin
          r    = dec_sum;
          cout = dcarry[4];
          vout = dv[1];
        end else if (item.narrow_mode) begin
          r    = {8'h00, bin8[7:0]};
          cout = bin8[8];
          vout = ~(a[7] ^ b[7]) & (a[7] ^ bin8[7]);
        end else begin
          r    = bin16[15:0];
          cout = bin16[16];
          vout = ~(a[15] ^ b[15]) & (a[15] ^ bin16[15]);
        end
      end
      default: r = a;
    endcase
  end

  assign acc_nxt = item.narrow_mode ? {acc[15:8], r[7:0]} : r;

  assign res.accumulator_out = acc_nxt;
  assign res.negative        = item.narrow_mode ? r[7] : r[15];
  assign res.zero            = item.narrow_mode ? (r[7:0] == 8'h00) : (r == 16'h0000);
  assign res.overflow_out    = vout;
  assign res.carry_out       = cout;

endmodule

### design/aabcd_exec.sv
module aabcd_exec (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  aabcd_pkg::in_item_t  s1_item,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aabcd_pkg::out_item_t out_data
);

  logic                 out_valid_r;
  aabcd_pkg::out_item_t out_data_r;
  logic [15:0]          acc_r;
  logic [15:0]          acc_nxt;
  aabcd_pkg::out_item_t res;

  aabcd_alu u_alu (
    .acc     (acc_r),
    .item    (s1_item),
    .acc_nxt (acc_nxt),
    .res     (res)
  );

  assign advance   = s1_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= 16'h0000;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      acc_r       <= acc_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

endmodule

### design/accumulator_alu_bcd_top.sv
// Accumulator unit of a 16-bit 6502-style core, native mode.
// Input channel in_valid / in_stall / in_data carries one operation item:
// command, operand, width and decimal flags, incoming carry and overflow.
// Result channel out_valid / out_stall / out_data returns one item per input:
// the new 16-bit accumulator plus negative, zero, overflow and carry.
// An item is taken on a clock edge with valid high and stall low.
// Path: an accepted item enters the input register, then the result register,
// which is loaded through the combinational alu and decimal adjust.
// Throughput: one item per cycle while out_stall is low; the accumulator
// register feeds back into the alu within that same cycle.
// When out_stall is high and a result is waiting, the result holds and the
// input register keeps its item; in_stall then rises only while that input
// register is occupied. Reset (rst_n low, synchronous) clears the accumulator
// to zero and empties both stages.
module accumulator_alu_bcd_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aabcd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aabcd_pkg::out_item_t out_data
);

  logic                s1_valid;
  aabcd_pkg::in_item_t s1_item;
  logic                advance;

  aabcd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  aabcd_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_empty_out_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("pending item did not reach the result register");

  a_drain_no_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result repeated after it was taken");

  a_advance_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !(in_valid && !in_stall)) |=> !s1_valid)
    else $error("input register not emptied after advance");
`endif

endmodule

### tb/accumulator_alu_bcd_top_test.sv
`timescale 1ns / 1ps

module accumulator_alu_bcd_top_test;

  // command codes the block leaves without an operation
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam int unsigned MAX_PRINTED    = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  aabcd_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  aabcd_pkg::out_item_t out_data;

  logic [15:0]          acc_model;
  aabcd_pkg::out_item_t pending_results[$];
  int unsigned          error_count;
  bit                   burst_mode;

  accumulator_alu_bcd_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one item to the accumulator copy and returns what the block should report
  function automatic aabcd_pkg::out_item_t predict_result(aabcd_pkg::in_item_t it);
    aabcd_pkg::out_item_t res;
    int unsigned mask, top, a, b, r, cout, vout;
    int unsigned digits, da, db, d, c;
    mask = it.narrow_mode ? 32'h00FF : 32'hFFFF;
    top  = it.narrow_mode ? 32'h0080 : 32'h8000;
    a    = 32'(acc_model) & mask;
    b    = 32'(it.operand) & mask;
    r    = a;
    cout = 32'(it.carry_in);
    vout = 32'(it.overflow_in);
    case (it.command)
      aabcd_pkg::CMD_LOAD: r = b;
      aabcd_pkg::CMD_OR:   r = a | b;
      aabcd_pkg::CMD_AND:  r = a & b;
      aabcd_pkg::CMD_XOR:  r = a ^ b;
      aabcd_pkg::CMD_ADD: begin
        if (!it.decimal_mode) begin
          r    = a + b + 32'(it.carry_in);
          vout = 32'(((~(a ^ b)) & (a ^ r) & top) != 0);
          cout = 32'(r > mask);
        end else begin
          digits = it.narrow_mode ? 2 : 4;
          r      = 0;
          c      = 32'(it.carry_in);
          vout   = 0;
          for (int i = 0; i < digits; i++) begin
            da = (a >> (4 * i)) & 32'hF;
            db = (b >> (4 * i)) & 32'hF;
            d  = da + db + c;
            // overflow is judged on the top digit before the +6 fixup
            if (i == digits - 1) vout = 32'(((~(da ^ db)) & (da ^ d) & 32'h8) != 0);
            if (d > 9) d += 6;
            c = 32'(d > 32'hF);
            r |= (d & 32'hF) << (4 * i);
          end
          cout = c;
        end
      end
      default: ;
    endcase
    r &= mask;
    acc_model = 16'((32'(acc_model) & ~mask) | r);
    res.accumulator_out = acc_model;
    res.negative        = (r & top) != 0;
    res.zero            = r == 0;
    res.overflow_out    = vout[0];
    res.carry_out       = cout[0];
    return res;
  endfunction

  function automatic aabcd_pkg::in_item_t make_op(logic [2:0] cmd, logic [15:0] opnd,
                                                  logic narrow, logic dec, logic cin,
                                                  logic vin);
    aabcd_pkg::in_item_t it;
    it.command      = cmd;
    it.operand      = opnd;
    it.narrow_mode  = narrow;
    it.decimal_mode = dec;
    it.carry_in     = cin;
    it.overflow_in  = vin;
    return it;
  endfunction

  function automatic logic [15:0] bcd_word();
    logic [15:0] w;
    for (int i = 0; i < 4; i++) w[i*4 +: 4] = 4'($urandom_range(0, 9));
    return w;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int pick;
    if (burst_mode) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_op(input aabcd_pkg::in_item_t item);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(item));
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_logic_ops();
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1));
    send_op(make_op(aabcd_pkg::CMD_OR,   16'h8001, 1'b0, 1'b0, 1'b1, 1'b1));
    send_op(make_op(aabcd_pkg::CMD_AND,  16'h0F0F, 1'b0, 1'b0, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_XOR,  16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0));
    // narrow width: operand high byte ignored, accumulator high byte kept
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'h1234, 1'b1, 1'b0, 1'b0, 1'b1));
    send_op(make_op(aabcd_pkg::CMD_OR,   16'hFF80, 1'b1, 1'b0, 1'b1, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_AND,  16'hFF00, 1'b1, 1'b1, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_XOR,  16'hAAFF, 1'b1, 1'b0, 1'b1, 1'b1));
    drain_results();
  endtask

  task automatic test_binary_add();
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_ADD,  16'h0001, 1'b0, 1'b0, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_ADD,  16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1));
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'h00FF, 1'b1, 1'b0, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_ADD,  16'hFF01, 1'b1, 1'b0, 1'b0, 1'b1));
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'h0080, 1'b1, 1'b0, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_ADD,  16'h0080, 1'b1, 1'b0, 1'b0, 1'b0));
    drain_results();
  endtask

  task automatic test_decimal_add();
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'h0099, 1'b1, 1'b1, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_ADD,  16'h0001, 1'b1, 1'b1, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'h9999, 1'b0, 1'b1, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_ADD,  16'h0001, 1'b0, 1'b1, 1'b0, 1'b1));
    // top digit overflows before correction
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'h0050, 1'b1, 1'b1, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_ADD,  16'h0050, 1'b1, 1'b1, 1'b0, 1'b0));
    // digits above nine go through the same rule
    send_op(make_op(aabcd_pkg::CMD_LOAD, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0));
    send_op(make_op(aabcd_pkg::CMD_ADD,  16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0));
    drain_results();
  endtask

  task automatic test_spare_commands();
    send_op(make_op(CMD_SPARE_FIRST, 16'h1234, 1'b1, 1'b0, 1'b1, 1'b0));
    send_op(make_op(CMD_SPARE_MID,   16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1));
    send_op(make_op(CMD_SPARE_LAST,  16'h0000, 1'b1, 1'b1, 1'b1, 1'b1));
    drain_results();
  endtask

  function automatic aabcd_pkg::in_item_t random_op();
    aabcd_pkg::in_item_t it;
    int                  pick;
    it.operand      = 16'($urandom);
    it.narrow_mode  = 1'($urandom);
    it.decimal_mode = 1'($urandom);
    it.carry_in     = 1'($urandom);
    it.overflow_in  = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 6)       it.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    else if (pick < 50) it.command = 3'($urandom_range(aabcd_pkg::CMD_LOAD,
                                                       aabcd_pkg::CMD_XOR));
    else                it.command = aabcd_pkg::CMD_ADD;
    if (it.command == aabcd_pkg::CMD_ADD && it.decimal_mode && $urandom_range(0, 3) != 0)
      it.operand = bcd_word();
    return it;
  endfunction

  task automatic test_random_mix(input int count);
    repeat (count) send_op(random_op());
    drain_results();
  endtask

  task automatic test_back_to_back(input int count);
    burst_mode = 1'b1;
    repeat (count) send_op(random_op());
    drain_results();
    burst_mode = 1'b0;
  endtask

  // decimal counting chains: load a packed decimal value, then keep adding to it, now and then a random item
  task automatic test_decimal_chains(input int count);
    int   sent;
    logic narrow;
    sent = 0;
    while (sent < count) begin
      narrow = 1'($urandom);
      send_op(make_op(aabcd_pkg::CMD_LOAD, bcd_word(), narrow, 1'b1, 1'($urandom),
                      1'($urandom)));
      sent++;
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 9) == 0) send_op(random_op());
        else send_op(make_op(aabcd_pkg::CMD_ADD, bcd_word(), narrow, 1'b1, 1'($urandom),
                             1'($urandom)));
        sent++;
      end
    end
    drain_results();
  endtask

  // result side: random stall stretches, some long, some quiet runs
  initial begin
    int run;
    out_stall = 1'b0;
    forever begin
      if (burst_mode) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 12);
        repeat (run) begin
          @(negedge clk);
          out_stall <= 1'b0;
        end
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (run) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    aabcd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no item pending");
      end else begin
        want = pending_results.pop_front();
        if (out_data.accumulator_out !== want.accumulator_out)
          report_mismatch($sformatf("accumulator_out got %h want %h",
                                    out_data.accumulator_out, want.accumulator_out));
        if (out_data.negative !== want.negative)
          report_mismatch($sformatf("negative got %b want %b",
                                    out_data.negative, want.negative));
        if (out_data.zero !== want.zero)
          report_mismatch($sformatf("zero got %b want %b", out_data.zero, want.zero));
        if (out_data.overflow_out !== want.overflow_out)
          report_mismatch($sformatf("overflow_out got %b want %b",
                                    out_data.overflow_out, want.overflow_out));
        if (out_data.carry_out !== want.carry_out)
          report_mismatch($sformatf("carry_out got %b want %b",
                                    out_data.carry_out, want.carry_out));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    acc_model   = 16'h0000;
    error_count = 0;
    burst_mode  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_logic_ops();
    test_binary_add();
    test_decimal_add();
    test_spare_commands();
    test_random_mix(600);
    test_back_to_back(200);
    test_decimal_chains(600);

    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
